### rtl/sspc_pkg.sv
// Package for the solvent surface point counter.
// Holds shared widths, codes, the controller state type and the command and status bundles.
// No dependencies.
package sspc_pkg;

    localparam int POS_W   = 24;
    localparam int RAD_W   = 12;
    localparam int SOLV_W  = 11;
    localparam int CNT_W   = 13;
    localparam int AREA_W  = 36;
    localparam int R_W     = 12;
    localparam int X_W     = 26;
    localparam int D_W     = 27;
    localparam int SQ_W    = 54;
    localparam int SUM_W   = 56;
    localparam int PROD_W  = 37;
    localparam int ENT_W   = 3 * POS_W + SOLV_W + 1;
    localparam int COUNT_LIMIT = 8191;

    localparam logic [SOLV_W-1:0] SOLV_RESET = 11'd358;

    typedef enum logic [1:0] {
        ACT_CENTER   = 2'd0,
        ACT_NEIGHBOR = 2'd1,
        ACT_POINT    = 2'd2,
        ACT_FINISH   = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NB_SQ,
        S_NB_CMP,
        S_PT_MUL,
        S_PT_ADD,
        S_SCAN,
        S_DRAIN,
        S_COMMIT,
        S_FIN_SQ,
        S_FIN_MUL,
        S_FIN_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic set_center;
        logic nb_load;
        logic nb_commit;
        logic pt_mul;
        logic pt_add;
        logic scan_issue;
        logic pt_commit;
        logic fin_sq;
        logic fin_mul;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    center_valid;
        logic    vdw_neg;
        logic    cnt_zero;
        logic    scan_last;
        logic    out_free;
    } t_status;

endpackage

### rtl/sspc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sspc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/sspc_ctrl.sv
// Controller state machine of the solvent surface point counter.
// Depends on sspc_pkg for the state type and the command and status bundles.
module sspc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  sspc_pkg::t_status i_status,
    output sspc_pkg::t_cmd    o_cmd
);

    sspc_pkg::t_state r_state, n_state;
    logic             r_drain, n_drain;

    // State and drain registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sspc_pkg::S_IDLE;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    // The drain register holds S_DRAIN so the pipeline can settle its flags after the last read.
    assign n_drain = (r_state == sspc_pkg::S_DRAIN) ? ~r_drain : 1'b0;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sspc_pkg::S_IDLE: begin
                if (i_valid) n_state = sspc_pkg::S_DECODE;
            end
            sspc_pkg::S_DECODE: begin
                if (i_status.action == sspc_pkg::ACT_CENTER || !i_status.center_valid) begin
                    n_state = sspc_pkg::S_IDLE;
                end else begin
                    unique case (i_status.action)
                        sspc_pkg::ACT_NEIGHBOR: begin
                            n_state = i_status.vdw_neg ? sspc_pkg::S_IDLE : sspc_pkg::S_NB_SQ;
                        end
                        sspc_pkg::ACT_POINT:  n_state = sspc_pkg::S_PT_MUL;
                        sspc_pkg::ACT_FINISH: n_state = sspc_pkg::S_FIN_SQ;
                        default:              n_state = sspc_pkg::S_IDLE;
                    endcase
                end
            end
            sspc_pkg::S_NB_SQ:  n_state = sspc_pkg::S_NB_CMP;
            sspc_pkg::S_NB_CMP: n_state = sspc_pkg::S_IDLE;
            sspc_pkg::S_PT_MUL: n_state = sspc_pkg::S_PT_ADD;
            sspc_pkg::S_PT_ADD: begin
                n_state = i_status.cnt_zero ? sspc_pkg::S_COMMIT : sspc_pkg::S_SCAN;
            end
            sspc_pkg::S_SCAN: begin
                if (i_status.scan_last) n_state = sspc_pkg::S_DRAIN;
            end
            sspc_pkg::S_DRAIN: begin
                if (r_drain) n_state = sspc_pkg::S_COMMIT;
            end
            sspc_pkg::S_COMMIT:  n_state = sspc_pkg::S_IDLE;
            sspc_pkg::S_FIN_SQ:  n_state = sspc_pkg::S_FIN_MUL;
            sspc_pkg::S_FIN_MUL: n_state = sspc_pkg::S_FIN_OUT;
            sspc_pkg::S_FIN_OUT: begin
                if (i_status.out_free) n_state = sspc_pkg::S_IDLE;
            end
            default: n_state = sspc_pkg::S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd            = '0;
        o_cmd.accept     = (r_state == sspc_pkg::S_IDLE) && i_valid;
        o_cmd.set_center = (r_state == sspc_pkg::S_DECODE) &&
                           (i_status.action == sspc_pkg::ACT_CENTER);
        o_cmd.nb_load    = (r_state == sspc_pkg::S_NB_SQ);
        o_cmd.nb_commit  = (r_state == sspc_pkg::S_NB_CMP);
        o_cmd.pt_mul     = (r_state == sspc_pkg::S_PT_MUL);
        o_cmd.pt_add     = (r_state == sspc_pkg::S_PT_ADD);
        o_cmd.scan_issue = (r_state == sspc_pkg::S_SCAN);
        o_cmd.pt_commit  = (r_state == sspc_pkg::S_COMMIT);
        o_cmd.fin_sq     = (r_state == sspc_pkg::S_FIN_SQ);
        o_cmd.fin_mul    = (r_state == sspc_pkg::S_FIN_MUL);
        o_cmd.out_load   = (r_state == sspc_pkg::S_FIN_OUT) && i_status.out_free;
    end

    assign o_stall = (r_state != sspc_pkg::S_IDLE);

endmodule

### rtl/sspc_datapath.sv
// Datapath of the solvent surface point counter: atom state, neighbor RAM,
// squared-distance unit, point projection, counters and area output register.
// Depends on sspc_pkg and sspc_ram.
module sspc_datapath #(
    parameter int MAX_NEIGHBORS = 128,
    parameter int MAX_POINTS    = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sspc_pkg::t_cmd                     i_cmd,
    output sspc_pkg::t_status                  o_status,
    input  logic                               i_cfg_wr_en,
    input  logic [sspc_pkg::SOLV_W-1:0]        i_cfg_wr_data,
    input  logic [1:0]                         i_action,
    input  logic signed [sspc_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [sspc_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [sspc_pkg::POS_W-1:0]  i_pos_z,
    input  logic signed [sspc_pkg::RAD_W-1:0]  i_vdw_radius,
    input  logic                               i_same_residue,
    input  logic                               i_stall,
    output logic                               o_valid,
    output logic [sspc_pkg::CNT_W-1:0]         o_full_points,
    output logic [sspc_pkg::CNT_W-1:0]         o_part_points,
    output logic [sspc_pkg::AREA_W-1:0]        o_full_area,
    output logic [sspc_pkg::AREA_W-1:0]        o_part_area,
    output logic                               o_neighbor_overflow
);

    localparam int AW      = $clog2(MAX_NEIGHBORS);
    localparam int CW      = $clog2(MAX_NEIGHBORS + 1);
    localparam int CNT_CAP = (MAX_POINTS < sspc_pkg::COUNT_LIMIT) ? MAX_POINTS
                                                                  : sspc_pkg::COUNT_LIMIT;
    localparam int POS_W   = sspc_pkg::POS_W;
    localparam int X_W     = sspc_pkg::X_W;
    localparam int D_W     = sspc_pkg::D_W;
    localparam int SQ_W    = sspc_pkg::SQ_W;
    localparam int SUM_W   = sspc_pkg::SUM_W;
    localparam int PROD_W  = sspc_pkg::PROD_W;
    localparam int SOLV_W  = sspc_pkg::SOLV_W;
    localparam int R_W     = sspc_pkg::R_W;
    localparam int CNT_W   = sspc_pkg::CNT_W;
    localparam int AREA_W  = sspc_pkg::AREA_W;
    localparam int ENT_W   = sspc_pkg::ENT_W;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(8192);
    localparam logic [PROD_W:0]   AREA_CAP   = {2'b00, {AREA_W{1'b1}}};

    // Latched request.
    sspc_pkg::t_action        r_act;
    logic signed [POS_W-1:0]  r_p [3];
    logic signed [sspc_pkg::RAD_W-1:0] r_vdw;
    logic                     r_same;

    logic [SOLV_W-1:0]        r_solv;
    logic signed [POS_W-1:0]  r_cpos [3];
    logic [SOLV_W-1:0]        r_crad;
    logic                     r_cv;
    logic [CW-1:0]            r_count;
    logic                     r_ovf;
    logic [CNT_W-1:0]         r_full;
    logic [CNT_W-1:0]         r_part;

    logic signed [PROD_W-1:0] r_prod [3];
    logic signed [X_W-1:0]    r_x [3];
    logic [AW-1:0]            r_k;
    logic                     r_rd_v;
    logic [SQ_W-1:0]          r_sq [3];
    logic [2*(R_W+1)-1:0]     r_rad2;
    logic                     r_s1_scan;
    logic                     r_s1_same;
    logic                     r_full_in;
    logic                     r_part_in;
    logic [2*R_W-1:0]         r_rsq;
    logic [AREA_W-1:0]        r_farea;
    logic [AREA_W-1:0]        r_parea;

    logic                     r_out_v;
    logic [CNT_W-1:0]         r_o_full;
    logic [CNT_W-1:0]         r_o_part;
    logic [AREA_W-1:0]        r_o_farea;
    logic [AREA_W-1:0]        r_o_parea;
    logic                     r_o_ovf;

    logic [R_W-1:0]           r_exp;
    logic [R_W:0]             nb_rad;
    logic [R_W:0]             sc_rad;
    logic [R_W:0]             rad_sel;
    logic [ENT_W-1:0]         ram_wdata;
    logic [ENT_W-1:0]         ram_rdata;
    logic signed [POS_W-1:0]  ram_pos [3];
    logic [SOLV_W-1:0]        ram_rad;
    logic                     ram_same;
    logic                     ram_we;
    logic                     store_full;
    logic [SUM_W-1:0]         dist_sum;
    logic                     in_reach;
    logic [PROD_W:0]          farea_full;
    logic [PROD_W:0]          parea_full;

    // Expanded radius of the center atom, with the live probe radius.
    assign r_exp = {1'b0, r_crad} + {1'b0, r_solv};

    // Request latch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act  <= sspc_pkg::t_action'(i_action);
            r_p[0] <= i_pos_x;
            r_p[1] <= i_pos_y;
            r_p[2] <= i_pos_z;
            r_vdw  <= i_vdw_radius;
            r_same <= i_same_residue;
        end
    end

    // Probe radius register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_solv <= sspc_pkg::SOLV_RESET;
        end else if (i_cfg_wr_en) begin
            r_solv <= i_cfg_wr_data;
        end
    end

    // Neighbor RAM fields.
    assign ram_wdata   = {r_p[0], r_p[1], r_p[2], r_vdw[SOLV_W-1:0], r_same};
    assign ram_pos[0]  = ram_rdata[ENT_W-1 -: POS_W];
    assign ram_pos[1]  = ram_rdata[ENT_W-1-POS_W -: POS_W];
    assign ram_pos[2]  = ram_rdata[ENT_W-1-2*POS_W -: POS_W];
    assign ram_rad     = ram_rdata[SOLV_W:1];
    assign ram_same    = ram_rdata[0];
    assign store_full  = (r_count >= CW'(MAX_NEIGHBORS));
    assign ram_we      = i_cmd.nb_commit && in_reach && !store_full;

    sspc_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_NEIGHBORS)
    ) u_nb_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (r_k),
        .o_rdata (ram_rdata)
    );

    // Atom state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv    <= 1'b0;
            r_crad  <= '0;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_full  <= '0;
            r_part  <= '0;
            for (int i = 0; i < 3; i++) r_cpos[i] <= '0;
        end else if (i_cmd.set_center) begin
            r_cv    <= !r_vdw[sspc_pkg::RAD_W-1];
            r_crad  <= r_vdw[SOLV_W-1:0];
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_full  <= '0;
            r_part  <= '0;
            for (int i = 0; i < 3; i++) r_cpos[i] <= r_p[i];
        end else begin
            if (i_cmd.nb_commit && in_reach) begin
                if (store_full) r_ovf <= 1'b1;
                else            r_count <= r_count + CW'(1);
            end
            if (i_cmd.pt_commit) begin
                if (!r_full_in && r_full < CNT_W'(CNT_CAP)) r_full <= r_full + CNT_W'(1);
                if (!r_part_in && r_part < CNT_W'(CNT_CAP)) r_part <= r_part + CNT_W'(1);
            end
        end
    end

    // Point projection onto the expanded sphere, rounded to Q.8.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            if (i_cmd.pt_mul) begin
                r_prod[i] <= $signed({1'b0, r_exp}) * r_p[i];
            end
            if (i_cmd.pt_add) begin
                r_x[i] <= X_W'((r_prod[i] + $signed(ROUND_HALF)) >>> 14) +
                          {{(X_W-POS_W){r_cpos[i][POS_W-1]}}, r_cpos[i]};
            end
        end
    end

    // Scan index and read valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k    <= '0;
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.scan_issue;
            if (i_cmd.pt_mul)          r_k <= '0;
            else if (i_cmd.scan_issue) r_k <= r_k + AW'(1);
        end
    end

    // Radius bounds for the neighbor filter and for the point test.
    assign nb_rad  = {1'b0, r_exp} + {2'b00, r_vdw[SOLV_W-1:0]} + {2'b00, r_solv};
    assign sc_rad  = {1'b0, {1'b0, ram_rad} + {1'b0, r_solv}};
    assign rad_sel = i_cmd.nb_load ? nb_rad : sc_rad;

    // Squared-distance stage: three axis squarers and the radius square.
    always_ff @(posedge i_clk) begin
        logic signed [D_W-1:0] a;
        logic signed [D_W-1:0] b;
        logic signed [D_W-1:0] d;
        if (i_cmd.nb_load || r_rd_v) begin
            for (int i = 0; i < 3; i++) begin
                if (i_cmd.nb_load) begin
                    a = {{(D_W-POS_W){r_p[i][POS_W-1]}}, r_p[i]};
                    b = {{(D_W-POS_W){r_cpos[i][POS_W-1]}}, r_cpos[i]};
                end else begin
                    a = {{(D_W-X_W){r_x[i][X_W-1]}}, r_x[i]};
                    b = {{(D_W-POS_W){ram_pos[i][POS_W-1]}}, ram_pos[i]};
                end
                d = a - b;
                r_sq[i] <= SQ_W'(d * d);
            end
            r_rad2    <= rad_sel * rad_sel;
            r_s1_same <= ram_same;
        end
    end

    // Compare stage.
    assign dist_sum = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
    assign in_reach = (dist_sum <= SUM_W'(r_rad2));

    // Burial flags for the current point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_scan <= 1'b0;
            r_full_in <= 1'b0;
            r_part_in <= 1'b0;
        end else begin
            r_s1_scan <= r_rd_v;
            if (i_cmd.pt_mul) begin
                r_full_in <= 1'b0;
                r_part_in <= 1'b0;
            end else if (r_s1_scan && in_reach) begin
                r_full_in <= 1'b1;
                if (r_s1_same) r_part_in <= 1'b1;
            end
        end
    end

    // Area products, saturated.
    assign farea_full = (PROD_W+1)'(r_full) * (PROD_W+1)'(r_rsq);
    assign parea_full = (PROD_W+1)'(r_part) * (PROD_W+1)'(r_rsq);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_sq) begin
            r_rsq <= r_exp * r_exp;
        end
        if (i_cmd.fin_mul) begin
            r_farea <= (farea_full > AREA_CAP) ? {AREA_W{1'b1}} : farea_full[AREA_W-1:0];
            r_parea <= (parea_full > AREA_CAP) ? {AREA_W{1'b1}} : parea_full[AREA_W-1:0];
        end
    end

    // Output register; it holds the result while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_full  <= r_full;
            r_o_part  <= r_part;
            r_o_farea <= r_farea;
            r_o_parea <= r_parea;
            r_o_ovf   <= r_ovf;
        end
    end

    assign o_valid             = r_out_v;
    assign o_full_points       = r_o_full;
    assign o_part_points       = r_o_part;
    assign o_full_area         = r_o_farea;
    assign o_part_area         = r_o_parea;
    assign o_neighbor_overflow = r_o_ovf;

    // Status to the controller.
    assign o_status.action       = r_act;
    assign o_status.center_valid = r_cv;
    assign o_status.vdw_neg      = r_vdw[sspc_pkg::RAD_W-1];
    assign o_status.cnt_zero     = (r_count == '0);
    assign o_status.scan_last    = (r_k == AW'(r_count - CW'(1)));
    assign o_status.out_free     = !r_out_v || !i_stall;

endmodule

### rtl/solvent_surface_point_count_top.sv
// Top level of the solvent surface point counter.
// Depends on sspc_pkg, sspc_ctrl, sspc_datapath and sspc_ram.
//
// Counts the sphere test points of one atom that no neighbor buries, and those
// that no same-residue neighbor buries. One request is worked at a time.
// A finish request also waits for the output register to empty. A request is
// ignored when it is for an excluded atom or when there is no valid center.
// A point request scans the stored neighbors, skipping the scan when the store
// is empty: the neighbor RAM read port feeds one neighbor per cycle through the
// squared-distance unit, and the pipeline then drains to settle its flags.
// The user must write the probe radius register with i_cfg_wr_en while the block is
// idle; the block itself does not enforce this.
module solvent_surface_point_count_top #(
    parameter int MAX_NEIGHBORS = 128,
    parameter int MAX_POINTS    = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [sspc_pkg::SOLV_W-1:0]        i_cfg_wr_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [1:0]                         i_action,
    input  logic signed [sspc_pkg::POS_W-1:0]  i_pos_x,
    input  logic signed [sspc_pkg::POS_W-1:0]  i_pos_y,
    input  logic signed [sspc_pkg::POS_W-1:0]  i_pos_z,
    input  logic signed [sspc_pkg::RAD_W-1:0]  i_vdw_radius,
    input  logic                               i_same_residue,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [sspc_pkg::CNT_W-1:0]         o_full_points,
    output logic [sspc_pkg::CNT_W-1:0]         o_part_points,
    output logic [sspc_pkg::AREA_W-1:0]        o_full_area,
    output logic [sspc_pkg::AREA_W-1:0]        o_part_area,
    output logic                               o_neighbor_overflow
);

    sspc_pkg::t_cmd    cmd;
    sspc_pkg::t_status status;

    // Controller.
    sspc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath.
    sspc_datapath #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .MAX_POINTS    (MAX_POINTS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_status            (status),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_wr_data       (i_cfg_wr_data),
        .i_action            (i_action),
        .i_pos_x             (i_pos_x),
        .i_pos_y             (i_pos_y),
        .i_pos_z             (i_pos_z),
        .i_vdw_radius        (i_vdw_radius),
        .i_same_residue      (i_same_residue),
        .i_stall             (i_stall),
        .o_valid             (o_valid),
        .o_full_points       (o_full_points),
        .o_part_points       (o_part_points),
        .o_full_area         (o_full_area),
        .o_part_area         (o_part_area),
        .o_neighbor_overflow (o_neighbor_overflow)
    );

endmodule

### rtl/sspc_checker.sv
// Port-level checker for the solvent surface point counter, with its bind.
// Depends on sspc_pkg and solvent_surface_point_count_top.
module sspc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [sspc_pkg::CNT_W-1:0]  o_full_points,
    input logic [sspc_pkg::CNT_W-1:0]  o_part_points,
    input logic [sspc_pkg::AREA_W-1:0] o_full_area,
    input logic [sspc_pkg::AREA_W-1:0] o_part_area
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_full_points) && $stable(o_full_area))
        else $error("stalled result changed");

    // An accepted request makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("block not busy after accepting a request");

    // A point free of all neighbors is also free of same-residue ones.
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_full_points <= o_part_points)
        else $error("full count exceeds partial count");

    // The areas follow the same order as the counts.
    a_area_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_full_area <= o_part_area)
        else $error("full area exceeds partial area");

endmodule

bind solvent_surface_point_count_top sspc_checker u_sspc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_full_points (o_full_points),
    .o_part_points (o_part_points),
    .o_full_area   (o_full_area),
    .o_part_area   (o_part_area)
);
